// ===== rtl/rhd_pkg.sv =====
// Package for the RLP header decoder: status codes, front phase encoding,
// prefix byte boundaries and the records passed between front, back and queues.
// No dependencies.
package rhd_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] PFX_SHORT_STR = 8'h80;
	localparam logic [7:0] PFX_LONG_STR  = 8'hB8;
	localparam logic [7:0] PFX_SHORT_LST = 8'hC0;
	localparam logic [7:0] PFX_LONG_LST  = 8'hF8;
	localparam logic [7:0] PFX_SINGLE    = 8'h81;
	localparam logic [7:0] LEN_BASE_STR  = 8'hB7;
	localparam logic [7:0] LEN_BASE_LST  = 8'hF7;
	localparam logic [63:0] LEN_LONG_MIN = 64'd56;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_SHORT    = 3'd1,
		ST_NONCANON = 3'd2,
		ST_LEADZERO = 3'd3,
		ST_LIST     = 3'd4,
		ST_LONG     = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'b001,
		PH_SINGLE = 3'b010,
		PH_LENGTH = 3'b100
	} phase_t;

	typedef enum logic [0:0] {
		REG_STRING_MODE    = 1'b0,
		REG_ALLOW_LEFTOVER = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic        err;
		status_t     status;
		logic        is_list;
		logic [3:0]  hlen;
		logic [63:0] plen;
		logic [31:0] rest;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic        is_list;
		logic [3:0]  hlen;
		logic [63:0] plen;
	} res_t;

endpackage

// ===== rtl/rlp_header_decoder_core.sv =====
// RLP header decoder top level: front stage, request queue, back stage and
// result queue. Depends on rhd_pkg, rhd_queue, rhd_front and rhd_back.
//
// Input channel: one encoded byte per beat with item_start on the prefix byte
// and bytes_left counting buffer bytes from this byte on. A beat is taken when
// push is high and full is low; one byte per cycle while full stays low.
// Result channel: at most one result per item, given once the header ends or
// an error is found. The oldest result sits on status, is_list, header_length
// and body_length while empty is low and leaves when pop is high.
// Path: the request is registered in the request queue, then the back stage
// result is registered in the result queue, which waits while that queue is full.
// Throughput: one byte per cycle while full is low, set by the front update.
// Receiver stall: the result queue fills, then the request queue, then full
// rises; each queue holds QUEUE_DEPTH beats.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 string_mode,
// 1 allow_leftover); write only while no item is in flight.
// Reset: clears both queues and the header state; string_mode 0,
// allow_leftover 1.
module rlp_header_decoder_core #(
	parameter int QUEUE_DEPTH = rhd_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [0:0]  cfg_data,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        item_start,
	input  logic [31:0] bytes_left,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  status,
	output logic        is_list,
	output logic [3:0]  header_length,
	output logic [63:0] body_length
);

	localparam int REQ_W = $bits(rhd_pkg::req_t);
	localparam int RES_W = $bits(rhd_pkg::res_t);

	logic               take;
	logic               req_push;
	rhd_pkg::req_t      req_in;
	logic [REQ_W-1:0]   req_rdata;
	rhd_pkg::req_t      req_out;
	logic               req_empty;
	logic               res_full;
	logic               move;
	rhd_pkg::res_t      res_in;
	logic [RES_W-1:0]   res_rdata;
	rhd_pkg::res_t      res_out;

	assign take    = push && !full;
	assign move    = !req_empty && !res_full;
	assign req_out = rhd_pkg::req_t'(req_rdata);
	assign res_out = rhd_pkg::res_t'(res_rdata);

	assign status        = res_out.status;
	assign is_list       = res_out.is_list;
	assign header_length = res_out.hlen;
	assign body_length   = res_out.plen;

	rhd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.data_byte  (data_byte),
		.item_start (item_start),
		.bytes_left (bytes_left),
		.req_push   (req_push),
		.req        (req_in)
	);

	rhd_queue #(
		.WIDTH (REQ_W),
		.DEPTH (QUEUE_DEPTH)
	) u_req_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (req_push),
		.wdata  (req_in),
		.full   (full),
		.pop    (move),
		.rdata  (req_rdata),
		.empty  (req_empty)
	);

	rhd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_out),
		.res       (res_in)
	);

	rhd_queue #(
		.WIDTH (RES_W),
		.DEPTH (QUEUE_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (move),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty)
	);

endmodule

// ===== rtl/rhd_queue.sv =====
// Small register FIFO used between the decoder stages and at the result side.
// Depends on nothing; width and depth come from parameters.
module rhd_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_FULL);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/rhd_front.sv =====
// Front stage: tracks the header of the current item byte by byte, gathers
// length bytes and issues a finish or error request. Depends on rhd_pkg.
module rhd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic [7:0]         data_byte,
	input  logic               item_start,
	input  logic [31:0]        bytes_left,
	output logic               req_push,
	output rhd_pkg::req_t      req
);

	rhd_pkg::phase_t phase_q, phase_n;
	logic [3:0]  due_q, due_n;
	logic [63:0] accum_q, accum_n;
	logic        list_q, list_n;
	logic [3:0]  pc_q, pc_n;

	logic        req_vld;
	logic        left_zero;
	logic [31:0] left_m1;
	logic [63:0] shifted;
	logic [3:0]  pc_inc;
	logic [3:0]  due_dec;
	logic        long_list;
	logic [7:0]  due_diff;
	logic [7:0]  short_len;

	assign left_zero = (bytes_left == 32'd0);
	assign left_m1   = bytes_left - 32'd1;
	assign shifted   = {accum_q[55:0], data_byte};
	assign pc_inc    = pc_q + 4'd1;
	assign due_dec   = due_q - 4'd1;
	assign long_list = (data_byte >= rhd_pkg::PFX_SHORT_LST);
	assign due_diff  = long_list ? (data_byte - rhd_pkg::LEN_BASE_LST)
		: (data_byte - rhd_pkg::LEN_BASE_STR);
	assign short_len = (data_byte >= rhd_pkg::PFX_SHORT_LST)
		? (data_byte - rhd_pkg::PFX_SHORT_LST) : (data_byte - rhd_pkg::PFX_SHORT_STR);

	assign req_push = take && req_vld;

	always_comb begin
		phase_n = phase_q;
		due_n   = due_q;
		accum_n = accum_q;
		list_n  = list_q;
		pc_n    = pc_q;
		req_vld = 1'b0;
		req     = '0;
		if (item_start) begin
			phase_n = rhd_pkg::PH_IDLE;
			due_n   = '0;
			accum_n = '0;
			list_n  = 1'b0;
			pc_n    = '0;
			if (left_zero) begin
				req_vld    = 1'b1;
				req.err    = 1'b1;
				req.status = rhd_pkg::ST_SHORT;
			end else if (data_byte < rhd_pkg::PFX_SHORT_STR) begin
				req_vld   = 1'b1;
				req.plen  = 64'd1;
				req.rest  = bytes_left;
			end else begin
				pc_n = 4'd1;
				if (data_byte < rhd_pkg::PFX_LONG_STR) begin
					if (data_byte == rhd_pkg::PFX_SINGLE) begin
						if (left_m1 == 32'd0) begin
							req_vld    = 1'b1;
							req.err    = 1'b1;
							req.status = rhd_pkg::ST_SHORT;
						end else begin
							phase_n = rhd_pkg::PH_SINGLE;
						end
					end else begin
						req_vld  = 1'b1;
						req.hlen = 4'd1;
						req.plen = {56'd0, short_len};
						req.rest = left_m1;
					end
				end else if (data_byte >= rhd_pkg::PFX_SHORT_LST
						&& data_byte < rhd_pkg::PFX_LONG_LST) begin
					req_vld     = 1'b1;
					req.is_list = 1'b1;
					req.hlen    = 4'd1;
					req.plen    = {56'd0, short_len};
					req.rest    = left_m1;
				end else begin
					list_n = long_list;
					due_n  = due_diff[3:0];
					if (left_m1 < {28'd0, due_diff[3:0]}) begin
						req_vld    = 1'b1;
						req.err    = 1'b1;
						req.status = rhd_pkg::ST_SHORT;
					end else begin
						phase_n = rhd_pkg::PH_LENGTH;
					end
				end
			end
		end else begin
			case (phase_q)
				rhd_pkg::PH_SINGLE: begin
					phase_n = rhd_pkg::PH_IDLE;
					req_vld = 1'b1;
					if (left_zero) begin
						req.err    = 1'b1;
						req.status = rhd_pkg::ST_SHORT;
					end else if (data_byte < rhd_pkg::PFX_SHORT_STR) begin
						req.err    = 1'b1;
						req.status = rhd_pkg::ST_NONCANON;
					end else begin
						req.hlen = 4'd1;
						req.plen = 64'd1;
						req.rest = bytes_left;
					end
				end
				rhd_pkg::PH_LENGTH: begin
					if (pc_q == 4'd1 && data_byte == 8'd0) begin
						phase_n    = rhd_pkg::PH_IDLE;
						req_vld    = 1'b1;
						req.err    = 1'b1;
						req.status = rhd_pkg::ST_LEADZERO;
					end else begin
						accum_n = shifted;
						pc_n    = pc_inc;
						due_n   = due_dec;
						if (due_dec == 4'd0) begin
							phase_n = rhd_pkg::PH_IDLE;
							req_vld = 1'b1;
							if (shifted < rhd_pkg::LEN_LONG_MIN) begin
								req.err    = 1'b1;
								req.status = rhd_pkg::ST_NONCANON;
							end else if (left_zero) begin
								req.err    = 1'b1;
								req.status = rhd_pkg::ST_SHORT;
							end else begin
								req.is_list = list_q;
								req.hlen    = pc_inc;
								req.plen    = shifted;
								req.rest    = left_m1;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rhd_pkg::PH_IDLE;
			due_q   <= '0;
			accum_q <= '0;
			list_q  <= 1'b0;
			pc_q    <= '0;
		end else if (take) begin
			phase_q <= phase_n;
			due_q   <= due_n;
			accum_q <= accum_n;
			list_q  <= list_n;
			pc_q    <= pc_n;
		end
	end

endmodule

// ===== rtl/rhd_back.sv =====
// Back stage: holds the mode registers and turns a request into a result,
// checking payload size against the buffer. Depends on rhd_pkg.
module rhd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [0:0]    cfg_index,
	input  logic [0:0]    cfg_data,
	input  rhd_pkg::req_t req,
	output rhd_pkg::res_t res
);

	logic        string_mode_q;
	logic        allow_leftover_q;
	logic [63:0] rest_w;

	assign rest_w = {32'd0, req.rest};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			string_mode_q    <= 1'b0;
			allow_leftover_q <= 1'b1;
		end else if (cfg_we) begin
			case (rhd_pkg::reg_index_t'(cfg_index))
				rhd_pkg::REG_STRING_MODE:    string_mode_q    <= cfg_data[0];
				rhd_pkg::REG_ALLOW_LEFTOVER: allow_leftover_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		res.status  = rhd_pkg::ST_OK;
		res.is_list = req.is_list;
		res.hlen    = req.hlen;
		res.plen    = req.plen;
		if (req.err) begin
			res.status  = req.status;
			res.is_list = 1'b0;
			res.hlen    = '0;
			res.plen    = '0;
		end else if (rest_w < req.plen) begin
			res.status  = rhd_pkg::ST_SHORT;
			res.is_list = 1'b0;
			res.hlen    = '0;
			res.plen    = '0;
		end else if (string_mode_q && req.is_list) begin
			res.status = rhd_pkg::ST_LIST;
		end else if (string_mode_q && !allow_leftover_q && rest_w > req.plen) begin
			res.status = rhd_pkg::ST_LONG;
		end
	end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for rlp_header_decoder_core: drives RLP byte streams
// through the push/full port, predicts each header result and checks the pop side.
// Depends on rhd_pkg and the RTL of rlp_header_decoder_core.
module testbench;

	typedef struct {
		logic [7:0]  data;
		logic        start;
		logic [31:0] left;
	} byte_beat_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [0:0]  cfg_data;
	logic        push;
	logic        full;
	logic [7:0]  data_byte;
	logic        item_start;
	logic [31:0] bytes_left;
	logic        empty;
	logic        pop;
	logic [2:0]  status;
	logic        is_list;
	logic [3:0]  header_length;
	logic [63:0] body_length;

	byte_beat_t    byte_stream[$];
	rhd_pkg::res_t expected_headers[$];

	// decoder state and register copies
	rhd_pkg::phase_t fe_phase = rhd_pkg::PH_IDLE;
	logic [3:0]  len_due = '0;
	logic [63:0] len_acc = '0;
	logic        lst_flag = 1'b0;
	logic [3:0]  hdr_count = '0;
	bit          mode_string = 1'b0;
	bit          mode_leftover = 1'b1;

	bit beat_taken = 1'b0;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int err_count = 0;
	int beats_in = 0;
	int results_seen = 0;
	int ok_seen = 0;

	rlp_header_decoder_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.push          (push),
		.full          (full),
		.data_byte     (data_byte),
		.item_start    (item_start),
		.bytes_left    (bytes_left),
		.empty         (empty),
		.pop           (pop),
		.status        (status),
		.is_list       (is_list),
		.header_length (header_length),
		.body_length   (body_length)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic rhd_pkg::res_t fail_header(rhd_pkg::status_t st);
		rhd_pkg::res_t r;
		r = '0;
		r.status = st;
		fe_phase = rhd_pkg::PH_IDLE;
		return r;
	endfunction

	function automatic rhd_pkg::res_t close_header(logic lst, logic [3:0] hlen,
			logic [63:0] plen, logic [63:0] rest);
		rhd_pkg::res_t r;
		fe_phase = rhd_pkg::PH_IDLE;
		if (rest < plen)
			return fail_header(rhd_pkg::ST_SHORT);
		r.is_list = lst;
		r.hlen = hlen;
		r.plen = plen;
		if (mode_string && lst)
			r.status = rhd_pkg::ST_LIST;
		else if (mode_string && !mode_leftover && rest > plen)
			r.status = rhd_pkg::ST_LONG;
		else
			r.status = rhd_pkg::ST_OK;
		return r;
	endfunction

	// returns 1 when this byte completes a header or ends it with an error
	function automatic bit decode_header_byte(logic [7:0] b, logic start, logic [31:0] left,
			output rhd_pkg::res_t r);
		logic [63:0] left64;
		left64 = {32'd0, left};
		r = '0;
		if (start) begin
			fe_phase = rhd_pkg::PH_IDLE;
			len_due = '0;
			len_acc = '0;
			lst_flag = 1'b0;
			hdr_count = '0;
			if (left64 == 0) begin
				r = fail_header(rhd_pkg::ST_SHORT);
				return 1'b1;
			end
			if (b < rhd_pkg::PFX_SHORT_STR) begin
				r = close_header(1'b0, 4'd0, 64'd1, left64);
				return 1'b1;
			end
			hdr_count = 4'd1;
			if (b < rhd_pkg::PFX_LONG_STR) begin
				if (b == rhd_pkg::PFX_SINGLE) begin
					if (left64 == 1) begin
						r = fail_header(rhd_pkg::ST_SHORT);
						return 1'b1;
					end
					fe_phase = rhd_pkg::PH_SINGLE;
					return 1'b0;
				end
				r = close_header(1'b0, 4'd1, {56'd0, b - rhd_pkg::PFX_SHORT_STR},
					left64 - 1);
				return 1'b1;
			end
			if (b >= rhd_pkg::PFX_SHORT_LST && b < rhd_pkg::PFX_LONG_LST) begin
				r = close_header(1'b1, 4'd1, {56'd0, b - rhd_pkg::PFX_SHORT_LST},
					left64 - 1);
				return 1'b1;
			end
			lst_flag = (b >= rhd_pkg::PFX_SHORT_LST);
			len_due = 4'(lst_flag ? b - rhd_pkg::LEN_BASE_LST : b - rhd_pkg::LEN_BASE_STR);
			if (left64 - 1 < {60'd0, len_due}) begin
				r = fail_header(rhd_pkg::ST_SHORT);
				return 1'b1;
			end
			fe_phase = rhd_pkg::PH_LENGTH;
			return 1'b0;
		end
		case (fe_phase)
			rhd_pkg::PH_SINGLE: begin
				if (left64 == 0) begin
					r = fail_header(rhd_pkg::ST_SHORT);
					return 1'b1;
				end
				if (b < rhd_pkg::PFX_SHORT_STR) begin
					r = fail_header(rhd_pkg::ST_NONCANON);
					return 1'b1;
				end
				r = close_header(1'b0, 4'd1, 64'd1, left64);
				return 1'b1;
			end
			rhd_pkg::PH_LENGTH: begin
				if (hdr_count == 4'd1 && b == 8'd0) begin
					r = fail_header(rhd_pkg::ST_LEADZERO);
					return 1'b1;
				end
				len_acc = {len_acc[55:0], b};
				hdr_count = hdr_count + 4'd1;
				len_due = len_due - 4'd1;
				if (len_due != 0)
					return 1'b0;
				if (len_acc < rhd_pkg::LEN_LONG_MIN) begin
					r = fail_header(rhd_pkg::ST_NONCANON);
					return 1'b1;
				end
				if (left64 == 0) begin
					r = fail_header(rhd_pkg::ST_SHORT);
					return 1'b1;
				end
				r = close_header(lst_flag, hdr_count, len_acc, left64 - 1);
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic void note_error(string msg);
		err_count++;
		if (err_count <= 10)
			$display("ERROR: %s", msg);
	endfunction

	task automatic add_beat(logic [7:0] data, logic start, logic [31:0] left);
		byte_beat_t bt;
		bt.data = data;
		bt.start = start;
		bt.left = left;
		byte_stream.push_back(bt);
	endtask

	// one RLP item header with a buffer that fits, has leftover, or falls short
	task automatic add_rlp_item();
		logic [7:0]  hdr[$];
		logic [63:0] plen;
		logic [63:0] total;
		logic [31:0] buflen;
		int unsigned kind;
		int unsigned nlen;
		int unsigned pick;
		int unsigned sendn;
		int i;
		kind = $urandom_range(0, 4);
		plen = '0;
		case (kind)
			0: begin
				hdr.push_back(8'($urandom_range(0, 127)));
				total = 64'd1;
			end
			1: begin
				plen = ($urandom_range(0, 3) == 0) ? 64'd1 : 64'($urandom_range(0, 55));
				hdr.push_back(rhd_pkg::PFX_SHORT_STR + plen[7:0]);
				if (plen == 1)
					hdr.push_back(8'($urandom_range(0, 255)));
				total = 64'd1 + plen;
			end
			2: begin
				plen = 64'($urandom_range(0, 55));
				hdr.push_back(rhd_pkg::PFX_SHORT_LST + plen[7:0]);
				total = 64'd1 + plen;
			end
			default: begin
				pick = $urandom_range(0, 9);
				nlen = (pick < 5) ? 1 : (pick < 8) ? 2 : $urandom_range(3, 8);
				plen = {$urandom, $urandom};
				if (nlen < 8)
					plen = plen & ((64'd1 << (8 * nlen)) - 64'd1);
				if ($urandom_range(0, 4) != 0) begin
					if (nlen == 1)
						plen = plen | 64'h38;
					if (plen[8 * nlen - 1 -: 8] == 8'd0)
						plen[8 * nlen - 1 -: 8] = 8'($urandom_range(1, 255));
				end
				hdr.push_back(((kind == 3) ? rhd_pkg::LEN_BASE_STR : rhd_pkg::LEN_BASE_LST)
					+ nlen[7:0]);
				for (i = nlen - 1; i >= 0; i--)
					hdr.push_back(plen[8 * i +: 8]);
				total = 64'd1 + 64'(nlen) + plen;
			end
		endcase
		pick = $urandom_range(0, 9);
		if (total > 64'hFFFF_0000 || pick == 9)
			buflen = $urandom;
		else if (pick < 6)
			buflen = total[31:0];
		else if (pick < 8)
			buflen = total[31:0] + $urandom_range(1, (pick == 6) ? 3 : 5000);
		else if (total > 1)
			buflen = total[31:0] - $urandom_range(1, total[31:0] - 1);
		else
			buflen = total[31:0];
		if (buflen == 0)
			buflen = 1;
		sendn = hdr.size();
		if (buflen < sendn)
			sendn = buflen;
		// cut the header short now and then; the next prefix drops it
		if (sendn > 1 && $urandom_range(0, 11) == 0)
			sendn = $urandom_range(1, sendn - 1);
		for (i = 0; i < sendn; i++)
			add_beat(hdr[i], i == 0, buflen - 32'(i));
		if ($urandom_range(0, 7) == 0)
			add_beat(8'($urandom_range(0, 255)), 1'b0, buflen - sendn);
	endtask

	// sender: hold a beat until taken, then advance
	always @(negedge clk) begin
		byte_beat_t nxt;
		bit go;
		if (arst_n) begin
			go = push && !beat_taken;
			if (!go && byte_stream.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
				nxt = byte_stream.pop_front();
				data_byte <= nxt.data;
				item_start <= nxt.start;
				bytes_left <= nxt.left;
				go = 1'b1;
			end
			push <= go;
		end
	end

	always @(negedge clk) begin
		if (hold_left != 0)
			hold_left <= hold_left - 1;
		else if (hold_req)
			hold_left <= 80;
	end

	always @(negedge clk) begin
		if (arst_n)
			pop <= (hold_left == 0) && ($urandom_range(0, 99) >= rx_stall_pct);
	end

	always @(posedge clk) begin
		rhd_pkg::res_t want;
		rhd_pkg::res_t got;
		string exp_s;
		string got_s;
		if (arst_n) begin
			if (pop && !empty) begin
				results_seen++;
				got.status = rhd_pkg::status_t'(status);
				got.is_list = is_list;
				got.hlen = header_length;
				got.plen = body_length;
				if (got.status == rhd_pkg::ST_OK)
					ok_seen++;
				if (expected_headers.size() == 0) begin
					note_error($sformatf("unexpected result beat: st %0d list %0d hlen %0d len %0h",
						got.status, got.is_list, got.hlen, got.plen));
				end else begin
					want = expected_headers.pop_front();
					if (got.status !== want.status || got.is_list !== want.is_list ||
							got.hlen !== want.hlen || got.plen !== want.plen) begin
						exp_s = $sformatf("result %0d: expected st %0d list %0d hlen %0d len %0h,",
							results_seen, want.status, want.is_list, want.hlen, want.plen);
						got_s = $sformatf(" got st %0d list %0d hlen %0d len %0h",
							got.status, got.is_list, got.hlen, got.plen);
						note_error({exp_s, got_s});
					end
				end
			end
			if (push && !full) begin
				beats_in++;
				if (decode_header_byte(data_byte, item_start, bytes_left, want))
					expected_headers.push_back(want);
			end
			beat_taken <= push && !full;
		end else begin
			beat_taken <= 1'b0;
		end
	end

	initial begin
		#2_000_000;
		$display("Timeout: %0d results still expected", expected_headers.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		bit cfg_sm[4];
		bit cfg_al[4];
		int tx_pct[4];
		int rx_pct[4];
		int target;
		int p;
		cfg_sm = '{1'b0, 1'b1, 1'b1, 1'b0};
		cfg_al = '{1'b1, 1'b1, 1'b0, 1'b0};
		tx_pct = '{0, 66, 0, 19};
		rx_pct = '{0, 0, 66, 19};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = rhd_pkg::REG_STRING_MODE;
		cfg_data = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		data_byte = '0;
		item_start = 1'b0;
		bytes_left = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (p = 0; p < 8; p++) begin
			@(negedge clk);
			cfg_we = 1'b1;
			cfg_index = rhd_pkg::REG_STRING_MODE;
			cfg_data = cfg_sm[p / 2];
			mode_string = cfg_sm[p / 2];
			@(negedge clk);
			cfg_index = rhd_pkg::REG_ALLOW_LEFTOVER;
			cfg_data = cfg_al[p / 2];
			mode_leftover = cfg_al[p / 2];
			@(negedge clk);
			cfg_we = 1'b0;
			@(posedge clk);
			tx_idle_pct = tx_pct[p % 4];
			rx_stall_pct = rx_pct[p % 4];
			if (p == 0) begin
				add_beat(8'h00, 1'b1, 32'd1);
				add_beat(8'h7F, 1'b1, 32'hFFFF_FFFF);
				add_beat(8'h80, 1'b1, 32'd1);
				add_beat(8'h81, 1'b1, 32'd2);
				add_beat(8'h80, 1'b0, 32'd1);
				add_beat(8'h81, 1'b1, 32'd2);
				add_beat(8'h7F, 1'b0, 32'd1);
				add_beat(8'h81, 1'b1, 32'd1);
				add_beat(8'hB7, 1'b1, 32'd56);
				add_beat(8'hB8, 1'b1, 32'd58);
				add_beat(8'h38, 1'b0, 32'd57);
				add_beat(8'hB8, 1'b1, 32'd3);
				add_beat(8'h00, 1'b0, 32'd2);
				add_beat(8'hB8, 1'b1, 32'd3);
				add_beat(8'h37, 1'b0, 32'd2);
				add_beat(8'hBF, 1'b1, 32'd9);
				for (int i = 8; i >= 1; i--)
					add_beat(8'hFF, 1'b0, 32'(i));
				add_beat(8'hC0, 1'b1, 32'd1);
				add_beat(8'hF8, 1'b1, 32'd58);
				add_beat(8'h38, 1'b0, 32'd57);
				add_beat(8'hFF, 1'b1, 32'd2);
				add_beat(8'h05, 1'b1, 32'd0);
				add_beat(8'h42, 1'b0, 32'd5);
				add_beat(8'hB9, 1'b1, 32'd100);
				add_beat(8'h01, 1'b0, 32'd99);
				add_beat(8'hC1, 1'b1, 32'd2);
			end
			if (p == 4) begin
				add_beat(8'hC0, 1'b1, 32'd1);
				add_beat(8'h80, 1'b1, 32'd3);
				add_beat(8'h80, 1'b1, 32'd1);
			end
			target = byte_stream.size() + 185;
			while (byte_stream.size() < target) begin
				if ($urandom_range(0, 99) < 85)
					add_rlp_item();
				else
					add_beat(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
						($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(1, 300));
			end
			// lone byte leaves the decoder idle before the next register write
			add_beat(8'h00, 1'b1, 32'd1);
			if (p == 0) begin
				hold_req = 1'b1;
				wait (hold_left != 0);
				hold_req = 1'b0;
			end
			do
				@(negedge clk);
			while (byte_stream.size() != 0 || push || expected_headers.size() != 0);
			repeat (8) @(negedge clk);
		end
		$display("Run covered %0d input beats over 8 register/idle phases, %0d results (%0d ok)",
			beats_in, results_seen, ok_seen);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
